FILE: rtl/modbus_request_frame_builder_assert.svh
// ----------------------------------------------------------------------------
// Modbus request frame builder assertion macros
// Shorthand for clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef MODBUS_REQUEST_FRAME_BUILDER_ASSERT_SVH
`define MODBUS_REQUEST_FRAME_BUILDER_ASSERT_SVH

// Same-cycle implication.
`define MRFB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame builder check failed");

// Next-cycle implication.
`define MRFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame builder check failed");

`endif

FILE: rtl/mrfb_pkg.sv
// ----------------------------------------------------------------------------
// Modbus request frame builder package
// Field widths, request kinds, Modbus codes and sequencer positions.
// ----------------------------------------------------------------------------
package mrfb_pkg;

    localparam int KIND_W = 4;
    localparam int BYTE_W = 8;
    localparam int POS_W  = 5;

    // Frame body bytes: 6 for the first frame, 11 for the second.
    localparam int BODY_BYTES = 17;
    localparam int BODY_W     = BODY_BYTES * BYTE_W;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } mrfb_state_t;

    // Request kinds
    localparam logic [KIND_W-1:0] REQ_RESOLUTION     = 4'd0;
    localparam logic [KIND_W-1:0] REQ_BAUD           = 4'd1;
    localparam logic [KIND_W-1:0] REQ_SMOOTHING      = 4'd2;
    localparam logic [KIND_W-1:0] REQ_TARE           = 4'd3;
    localparam logic [KIND_W-1:0] REQ_SPEED          = 4'd4;
    localparam logic [KIND_W-1:0] REQ_ZERO_CAL       = 4'd5;
    localparam logic [KIND_W-1:0] REQ_WEIGHT_CAL     = 4'd6;
    localparam logic [KIND_W-1:0] REQ_READ_WEIGHT    = 4'd7;
    localparam logic [KIND_W-1:0] REQ_READ_RESOLUTION = 4'd8;
    localparam logic [KIND_W-1:0] REQ_READ_BAUD      = 4'd9;
    localparam logic [KIND_W-1:0] REQ_READ_SPEED     = 4'd10;
    localparam logic [KIND_W-1:0] REQ_READ_SMOOTHING = 4'd11;

    // Modbus function codes
    localparam logic [BYTE_W-1:0] FC_READ_HOLDING   = 8'h03;
    localparam logic [BYTE_W-1:0] FC_WRITE_SINGLE   = 8'h06;
    localparam logic [BYTE_W-1:0] FC_WRITE_MULTIPLE = 8'h10;

    // Device register addresses (low byte)
    localparam logic [BYTE_W-1:0] REG_WEIGHT     = 8'h00;
    localparam logic [BYTE_W-1:0] REG_CAL_VALUE  = 8'h08;
    localparam logic [BYTE_W-1:0] REG_BAUD       = 8'h0b;
    localparam logic [BYTE_W-1:0] REG_SMOOTHING  = 8'h0c;
    localparam logic [BYTE_W-1:0] REG_RESOLUTION = 8'h0e;
    localparam logic [BYTE_W-1:0] REG_SPEED      = 8'h10;
    localparam logic [BYTE_W-1:0] REG_TARE       = 8'h11;
    localparam logic [BYTE_W-1:0] REG_CAL        = 8'h12;

    localparam logic [BYTE_W-1:0] CAL_REG_COUNT  = 8'h02;
    localparam logic [BYTE_W-1:0] CAL_BYTE_COUNT = 8'h04;

    // Sequencer byte positions
    localparam logic [POS_W-1:0] POS_F1_CRC_LO = 5'd6;
    localparam logic [POS_W-1:0] POS_F1_CRC_HI = 5'd7;
    localparam logic [POS_W-1:0] POS_F2_CRC_LO = 5'd19;
    localparam logic [POS_W-1:0] POS_F2_CRC_HI = 5'd20;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Configuration registers
    localparam logic CFG_ID_LIMIT        = 1'b0;
    localparam logic CFG_SMOOTHING_LIMIT = 1'b1;

    localparam logic [7:0]  ID_LIMIT_RESET        = 8'd32;
    localparam logic [15:0] SMOOTHING_LIMIT_RESET = 16'd30;

    function automatic logic [BYTE_W-1:0] write_reg(input logic [KIND_W-1:0] kind);
        logic [BYTE_W-1:0] r;
        case (kind)
            REQ_RESOLUTION: r = REG_RESOLUTION;
            REQ_BAUD:       r = REG_BAUD;
            REQ_SMOOTHING:  r = REG_SMOOTHING;
            REQ_TARE:       r = REG_TARE;
            REQ_SPEED:      r = REG_SPEED;
            default:        r = REG_CAL;
        endcase
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] read_reg(input logic [KIND_W-1:0] kind);
        logic [BYTE_W-1:0] r;
        case (kind)
            REQ_READ_RESOLUTION: r = REG_RESOLUTION;
            REQ_READ_BAUD:       r = REG_BAUD;
            REQ_READ_SPEED:      r = REG_SPEED;
            REQ_READ_SMOOTHING:  r = REG_SMOOTHING;
            default:             r = REG_WEIGHT;
        endcase
        return r;
    endfunction

    // One byte through the reflected CRC-16, eight shift steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [BYTE_W-1:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/mrfb_if.sv
// ----------------------------------------------------------------------------
// Modbus request frame builder channels
// Request channel and frame byte channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mrfb_req_if;
    import mrfb_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] req_type;
    logic [7:0]        device_id;
    logic [7:0]        value_high;
    logic [7:0]        value_low;

    modport source (output valid, req_type, device_id, value_high, value_low,
                    input ready);
    modport sink (input valid, req_type, device_id, value_high, value_low,
                  output ready);
endinterface

interface mrfb_byte_if;
    import mrfb_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              end_of_frame;
    logic              last_of_run;

    modport source (output valid, frame_byte, end_of_frame, last_of_run,
                    input ready);
    modport sink (input valid, frame_byte, end_of_frame, last_of_run,
                  output ready);
endinterface

FILE: rtl/modbus_request_frame_builder.sv
// ----------------------------------------------------------------------------
// Modbus RTU request frame builder
// Turns one request into the bytes of its Modbus RTU frame(s) with CRC-16.
// ----------------------------------------------------------------------------
// Usage:
//   req  : request items (req_type, device_id, value_high, value_low).
//   frm  : one item per frame byte, transmit order; end_of_frame marks the
//          high CRC byte of a frame, last_of_run the final byte of a request.
//   APB  : id_limit at 0x0, smoothing_limit at 0x4; pready is tied high.
// Timing:
//   A request is taken and loaded into a byte shift register.
//   The sequencer emits one byte per cycle while the output is free, so a
//   single frame is 8 bytes and a weighted calibration 21 bytes; the CRC
//   unit folds one body byte per cycle while bytes are emitted. A request
//   is registered into the sequencer before its first byte is registered
//   at the output; a request that emits nothing leaves the sequencer idle.
//   The next request is taken once the last byte is in the output register.
// Reset: sequencer idle, output empty, limits back to 32 and 30.
// Stall: while frm.ready is low and a byte waits, the output register and the sequencer hold.
// ----------------------------------------------------------------------------
`include "modbus_request_frame_builder_assert.svh"

module modbus_request_frame_builder (
    input  logic                 clk,
    input  logic                 rst_n,
    mrfb_req_if.sink             req,
    mrfb_byte_if.source          frm,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import mrfb_pkg::*;

    mrfb_state_t          state_reg, state_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [POS_W-1:0]     last_pos_reg, last_pos_next;
    logic [BODY_W-1:0]    body_reg, body_next;
    logic [15:0]          crc_reg, crc_next;
    logic                 out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]    out_byte_reg, out_byte_next;
    logic                 out_eof_reg, out_eof_next;
    logic                 out_last_reg, out_last_next;
    logic [7:0]           id_limit_reg;
    logic [15:0]          smoothing_limit_reg;

    logic                 accept;
    logic                 emit;
    logic                 is_crc_lo;
    logic                 is_crc_hi;
    logic [BYTE_W-1:0]    cur_byte;

    logic                 id_ok;
    logic [7:0]           load_addr;
    logic [15:0]          load_val;
    logic [15:0]          first_val;
    logic [BODY_W-1:0]    load_body;
    logic [POS_W-1:0]     load_last;
    logic                 load_run;

    // ---------------- configuration ----------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_limit_reg        <= ID_LIMIT_RESET;
            smoothing_limit_reg <= SMOOTHING_LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[2])
                CFG_ID_LIMIT:        id_limit_reg        <= pwdata[7:0];
                CFG_SMOOTHING_LIMIT: smoothing_limit_reg <= pwdata[15:0];
                default:             id_limit_reg        <= id_limit_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            CFG_ID_LIMIT:        prdata = {24'h000000, id_limit_reg};
            CFG_SMOOTHING_LIMIT: prdata = {16'h0000, smoothing_limit_reg};
            default:             prdata = 32'h00000000;
        endcase
    end

    // ---------------- request decode ----------------
    assign id_ok     = (req.device_id != 8'h00) && (req.device_id <= id_limit_reg);
    assign load_addr = id_ok ? req.device_id : 8'h01;
    assign load_val  = {req.value_high, req.value_low};

    always_comb
    begin
        first_val = load_val;
        case (req.req_type)
            REQ_SMOOTHING:
            begin
                if (load_val > smoothing_limit_reg)
                begin
                    first_val = 16'h0001;
                end
            end
            REQ_SPEED:
            begin
                if (load_val > 16'h0001)
                begin
                    first_val = 16'h0000;
                end
            end
            REQ_ZERO_CAL:   first_val = 16'h0001;
            REQ_WEIGHT_CAL: first_val = 16'h0002;
            default:        first_val = load_val;
        endcase
    end

    always_comb
    begin
        load_body = '0;
        load_last = POS_F1_CRC_HI;
        load_run  = 1'b0;
        if (req.req_type <= REQ_WEIGHT_CAL)
        begin
            load_run = 1'b1;
            load_body[BODY_W-1 -: 48] = {load_addr, FC_WRITE_SINGLE, 8'h00,
                                         write_reg(req.req_type), first_val};
            if (req.req_type == REQ_WEIGHT_CAL)
            begin
                load_last = POS_F2_CRC_HI;
                load_body[BODY_W-49 -: 88] = {load_addr, FC_WRITE_MULTIPLE, 8'h00,
                                              REG_CAL_VALUE, 8'h00, CAL_REG_COUNT,
                                              CAL_BYTE_COUNT, req.value_high,
                                              req.value_low, 16'h0000};
            end
        end
        else if (req.req_type <= REQ_READ_SMOOTHING && id_ok)
        begin
            load_run = 1'b1;
            load_body[BODY_W-1 -: 48] = {load_addr, FC_READ_HOLDING, 8'h00,
                                         read_reg(req.req_type), 8'h00,
                                         (req.req_type == REQ_READ_WEIGHT) ?
                                         8'h02 : 8'h01};
        end
    end

    // ---------------- byte sequencer ----------------
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign emit      = (state_reg == ST_RUN) && (!out_valid_reg || frm.ready);
    assign is_crc_lo = (pos_reg == POS_F1_CRC_LO) || (pos_reg == POS_F2_CRC_LO);
    assign is_crc_hi = (pos_reg == POS_F1_CRC_HI) || (pos_reg == POS_F2_CRC_HI);

    always_comb
    begin
        if (is_crc_lo)
        begin
            cur_byte = crc_reg[7:0];
        end
        else if (is_crc_hi)
        begin
            cur_byte = crc_reg[15:8];
        end
        else
        begin
            cur_byte = body_reg[BODY_W-1 -: BYTE_W];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        last_pos_next  = last_pos_reg;
        body_next      = body_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_eof_next   = out_eof_reg;
        out_last_next  = out_last_reg;

        // drop the output item once taken
        if (out_valid_reg && frm.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && load_run)
                begin
                    state_next    = ST_RUN;
                    pos_next      = '0;
                    last_pos_next = load_last;
                    body_next     = load_body;
                    crc_next      = CRC_INIT;
                end
            end
            ST_RUN:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = cur_byte;
                    out_eof_next   = is_crc_hi;
                    out_last_next  = (pos_reg == last_pos_reg);
                    if (is_crc_hi)
                    begin
                        crc_next = CRC_INIT;
                    end
                    else if (!is_crc_lo)
                    begin
                        // advance the body shift register one byte
                        crc_next  = crc_byte(crc_reg, cur_byte);
                        body_next = {body_reg[BODY_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
                    end
                    if (pos_reg == last_pos_reg)
                    begin
                        state_next = ST_IDLE;
                        pos_next   = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 5'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            last_pos_reg  <= POS_F1_CRC_HI;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            last_pos_reg  <= last_pos_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        body_reg     <= body_next;
        out_byte_reg <= out_byte_next;
        out_eof_reg  <= out_eof_next;
        out_last_reg <= out_last_next;
    end

    assign frm.valid        = out_valid_reg;
    assign frm.frame_byte   = out_byte_reg;
    assign frm.end_of_frame = out_eof_reg;
    assign frm.last_of_run  = out_last_reg;

    // ---------------- assertions ----------------
    `MRFB_ASSERT_NEXT(a_crc_restart, clk, rst_n, emit && is_crc_hi, crc_reg == CRC_INIT)
    `MRFB_ASSERT_NOW(a_last_ends_frame, clk, rst_n, frm.valid && frm.last_of_run,
                     frm.end_of_frame)
    `MRFB_ASSERT_NOW(a_pos_bound, clk, rst_n, state_reg == ST_RUN,
                     pos_reg <= last_pos_reg)

endmodule
